// ===== rtl/smms_pkg.sv =====
// shared types and constants for the sliding median moisture scaler
`default_nettype none
package smms_pkg;

  localparam int unsigned WINDOW_DEF     = 50;
  localparam int unsigned COUNT_BITS_DEF = 16;
  localparam int unsigned CFG_IDX_BITS   = 1;
  localparam int unsigned CFG_DATA_BITS  = 16;
  localparam logic [15:0] DRY_RESET      = 16'd800;
  localparam logic [15:0] WET_RESET      = 16'd18000;
  localparam logic [6:0]  PCT_FULL       = 7'd100;

  localparam logic [CFG_IDX_BITS-1:0] REG_DRY = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_WET = 1'b1;

  typedef enum logic {
    MODE_SAMPLE  = 1'b0,
    MODE_COMPUTE = 1'b1
  } mode_t;

  typedef struct packed {
    logic        mode;
    logic [15:0] raw_count;
  } in_item_t;

  typedef struct packed {
    logic [6:0]  moisture_percent;
    logic [15:0] median_count;
    logic [5:0]  samples_held;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RANK,
    ST_PICK,
    ST_DIV,
    ST_DONE
  } state_t;

  // broadcast from the sequencer to every cell
  typedef struct packed {
    logic shift_in;
    logic rank_load;
    logic rank_step;
  } cell_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/sliding_median_moisture_scaler.sv =====
// sliding median moisture scaler top level
// A sample request (mode 0) pushes raw_count into a chain of WINDOW cells; the
// oldest count falls off the far end once the chain is full. A sample gives
// no result.
// A compute request (mode 1) passes every held count past all cells, one per
// cycle; each cell counts the held counts below and equal to its own. The
// cells are then searched one a cycle from the newest until the one of rank
// fill_count/2 is found. A serial divider then works out the percentage, one
// quotient bit per cycle. When the window is empty the request goes straight
// to the done state, skipping ranking and division.
// One request is worked at a time; in_stall is high while busy or while a
// result waits in the output register.
// Reset empties the window, clears the last median and loads dry 800 and
// wet 18000. A waiting result holds while out_stall is high, blocking requests.
`default_nettype none
module sliding_median_moisture_scaler #(
  parameter int unsigned WINDOW     = smms_pkg::WINDOW_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire smms_pkg::in_item_t                   in_item,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output smms_pkg::out_item_t                       out_item,
  input  wire logic                                 cfg_we,
  input  wire logic [smms_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  wire logic [smms_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  localparam int unsigned COUNT_BITS = smms_pkg::COUNT_BITS_DEF;
  localparam int unsigned RANK_BITS = $clog2(WINDOW + 1);
  localparam int unsigned IDX_BITS  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned NUM_BITS  = 24;

  smms_pkg::state_t    state, state_next;
  smms_pkg::cell_ctl_t ctl;

  logic [15:0]           dry_count, wet_count;
  logic [RANK_BITS-1:0]  fill_count;
  logic [15:0]           last_median;
  logic [COUNT_BITS-1:0] median;
  logic                  found;
  logic [IDX_BITS-1:0]   scan;
  logic [RANK_BITS-1:0]  tap;
  logic [RANK_BITS-1:0]  steps;
  logic [COUNT_BITS-1:0] probe;
  logic                  probe_valid;
  logic                  neg;
  logic                  den_zero;
  logic                  div_start, div_busy;
  logic [NUM_BITS-1:0]   num, quot;
  logic [15:0]           den;

  logic [COUNT_BITS-1:0] cnt_a [WINDOW+1];
  logic                  val_a [WINDOW+1];
  logic [RANK_BITS-1:0]  below_a [WINDOW];
  logic [RANK_BITS-1:0]  same_a  [WINDOW];

  logic accept_in, accept_out;
  assign accept_in  = in_valid && !in_stall;
  assign accept_out = out_valid && !out_stall;
  assign in_stall   = (state != smms_pkg::ST_IDLE) || out_valid;

  assign cnt_a[0] = in_item.raw_count[COUNT_BITS-1:0];
  assign val_a[0] = 1'b1;

  // chain position of the cell under scan
  assign tap = RANK_BITS'(scan) + 1'b1;

  for (genvar g = 0; g < WINDOW; g++) begin : g_cell
    smms_cell #(.COUNT_BITS(COUNT_BITS), .RANK_BITS(RANK_BITS)) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .prev_count (cnt_a[g]),
      .prev_valid (val_a[g]),
      .probe      (probe),
      .probe_valid(probe_valid),
      .count      (cnt_a[g+1]),
      .valid      (val_a[g+1]),
      .below      (below_a[g]),
      .same       (same_a[g])
    );
  end

  // probe register: the count under scan goes to every cell, which counts held counts below/equal to its own
  always_ff @(posedge clk) begin
    if (state == smms_pkg::ST_RANK) begin
      probe       <= cnt_a[tap];
      probe_valid <= val_a[tap];
    end else begin
      probe_valid <= 1'b0;
    end
  end

  // rank match search over cells, one cell a cycle
  logic [RANK_BITS-1:0] k;
  logic [RANK_BITS:0]   hi;
  assign k  = fill_count >> 1;
  assign hi = {1'b0, below_a[scan]} + {1'b0, same_a[scan]};

  always_comb begin
    state_next = state;
    ctl        = '0;
    div_start  = 1'b0;
    unique case (state)
      smms_pkg::ST_IDLE: begin
        if (accept_in) begin
          if (in_item.mode == smms_pkg::MODE_SAMPLE) begin
            ctl.shift_in = 1'b1;
          end else if (fill_count == '0) begin
            state_next = smms_pkg::ST_DONE;
          end else begin
            ctl.rank_load = 1'b1;
            state_next    = smms_pkg::ST_RANK;
          end
        end
      end
      smms_pkg::ST_RANK: begin
        ctl.rank_step = 1'b1;
        if (steps == RANK_BITS'(WINDOW)) begin
          state_next = smms_pkg::ST_PICK;
        end
      end
      smms_pkg::ST_PICK: begin
        if (found || scan == IDX_BITS'(WINDOW - 1)) begin
          state_next = smms_pkg::ST_DIV;
          div_start  = 1'b1;
        end
      end
      smms_pkg::ST_DIV: begin
        if (!div_busy && !div_start) begin
          state_next = smms_pkg::ST_DONE;
        end
      end
      smms_pkg::ST_DONE: begin
        state_next = smms_pkg::ST_IDLE;
      end
      default: state_next = smms_pkg::ST_IDLE;
    endcase
  end

  logic hit;
  assign hit = val_a[tap] && ({1'b0, below_a[scan]} <= {1'b0, k})
               && ({1'b0, k} < hi);

  // signed difference of the count under scan against dry, and of wet against dry
  logic [16:0] dm, dw;
  assign dm = {1'b0, cnt_a[tap][15:0]} - {1'b0, dry_count};
  assign dw = {1'b0, wet_count} - {1'b0, dry_count};

  always_comb begin
    found = hit;
  end

  logic [15:0] mag_m, mag_w;
  assign mag_m = dm[16] ? 16'(-dm) : dm[15:0];
  assign mag_w = dw[16] ? 16'(-dw) : dw[15:0];
  assign num   = NUM_BITS'(mag_m) * NUM_BITS'(7'd100);
  assign den   = mag_w;

  smms_div #(.N_BITS(NUM_BITS), .D_BITS(16)) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (num),
    .den  (den),
    .busy (div_busy),
    .quot (quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= smms_pkg::ST_IDLE;
      fill_count  <= '0;
      last_median <= '0;
      dry_count   <= smms_pkg::DRY_RESET;
      wet_count   <= smms_pkg::WET_RESET;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_index)
          smms_pkg::REG_DRY: dry_count <= cfg_data;
          smms_pkg::REG_WET: wet_count <= cfg_data;
          default: ;
        endcase
      end
      if (ctl.shift_in && fill_count != RANK_BITS'(WINDOW)) begin
        fill_count <= fill_count + 1'b1;
      end
      if (accept_out) begin
        out_valid <= 1'b0;
      end
      if (state == smms_pkg::ST_DONE) begin
        out_valid <= 1'b1;
        out_item.median_count <= (fill_count == '0) ? last_median : 16'(median);
        out_item.samples_held <= 6'(fill_count);
        if (fill_count == '0 || den_zero || neg) begin
          out_item.moisture_percent <= '0;
        end else if (quot > NUM_BITS'(smms_pkg::PCT_FULL)) begin
          out_item.moisture_percent <= smms_pkg::PCT_FULL;
        end else begin
          out_item.moisture_percent <= quot[6:0];
        end
        if (fill_count != '0) begin
          last_median <= 16'(median);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rank_load) begin
      scan  <= '0;
      steps <= '0;
    end else if (state == smms_pkg::ST_RANK) begin
      steps <= steps + 1'b1;
      scan  <= (scan == IDX_BITS'(WINDOW - 1) || steps == RANK_BITS'(WINDOW)) ?
               '0 : scan + 1'b1;
    end else if (state == smms_pkg::ST_PICK) begin
      if (hit) begin
        median <= cnt_a[tap];
      end else begin
        scan <= scan + 1'b1;
      end
    end
    if (div_start) begin
      neg      <= (dm[16] != dw[16]) && (dm != '0);
      den_zero <= (dw == '0);
    end
  end

`ifndef SYNTH
  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    (state != smms_pkg::ST_IDLE) |-> in_stall)
    else $error("request taken while busy");
  a_fill_max: assert property (@(posedge clk) disable iff (rst)
    fill_count <= RANK_BITS'(WINDOW))
    else $error("fill count beyond window");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_item)))
    else $error("stalled result changed");
  a_pct_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_item.moisture_percent <= smms_pkg::PCT_FULL))
    else $error("percentage out of range");
`endif

endmodule
`default_nettype wire

// ===== rtl/smms_cell.sv =====
// one window cell: holds a count and counts how many held counts rank below it and equal it
`default_nettype none
module smms_cell #(
  parameter int unsigned COUNT_BITS = smms_pkg::COUNT_BITS_DEF,
  parameter int unsigned RANK_BITS  = 6
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire smms_pkg::cell_ctl_t   ctl,
  input  wire logic [COUNT_BITS-1:0] prev_count,
  input  wire logic                  prev_valid,
  input  wire logic [COUNT_BITS-1:0] probe,
  input  wire logic                  probe_valid,
  output logic [COUNT_BITS-1:0]      count,
  output logic                       valid,
  output logic [RANK_BITS-1:0]       below,
  output logic [RANK_BITS-1:0]       same
);

  always_ff @(posedge clk) begin
    if (ctl.shift_in) begin
      count <= prev_count;
    end
    if (ctl.rank_load) begin
      below <= '0;
      same  <= '0;
    end else if (ctl.rank_step && probe_valid && valid) begin
      if (probe < count) begin
        below <= below + 1'b1;
      end else if (probe == count) begin
        same <= same + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.shift_in) begin
      valid <= prev_valid;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/smms_div.sv =====
// serial restoring divider, one quotient bit a cycle
`default_nettype none
module smms_div #(
  parameter int unsigned N_BITS = 24,
  parameter int unsigned D_BITS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [N_BITS-1:0] num,
  input  wire logic [D_BITS-1:0] den,
  output logic                   busy,
  output logic [N_BITS-1:0]      quot
);

  localparam int unsigned CNT_BITS = $clog2(N_BITS + 1);

  logic [D_BITS:0]       rem;
  logic [D_BITS-1:0]     dreg;
  logic [CNT_BITS-1:0]   cnt;
  logic [D_BITS+1:0]     trial;

  assign trial = {rem, quot[N_BITS-1]} - {2'b00, dreg};

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quot <= num;
      dreg <= den;
    end else if (busy) begin
      if (!trial[D_BITS+1]) begin
        rem <= trial[D_BITS:0];
      end else begin
        rem <= {rem[D_BITS-1:0], quot[N_BITS-1]};
      end
      quot <= {quot[N_BITS-2:0], !trial[D_BITS+1]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_BITS'(N_BITS);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_BITS'(1)) begin
        busy <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire
